### src/tls_pkg.sv
`default_nettype none
package tls_pkg;

  localparam int LEN_BITS = 16;
  localparam int POS_BITS = 32;
  localparam int NUM_KW = 6;
  localparam int MAX_TOK = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_DEF    = 4'd1,
    KIND_EXTERN = 4'd2,
    KIND_IF     = 4'd3,
    KIND_ELSE   = 4'd4,
    KIND_FOR    = 4'd5,
    KIND_IN     = 4'd6,
    KIND_IDENT  = 4'd7,
    KIND_NUMBER = 4'd8,
    KIND_DOTDOT = 4'd9,
    KIND_SINGLE = 4'd10
  } tok_kind_t;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_IDENT   = 7'b0000010,
    MODE_INT     = 7'b0000100,
    MODE_INTDOT  = 7'b0001000,
    MODE_FRAC    = 7'b0010000,
    MODE_DOT     = 7'b0100000,
    MODE_COMMENT = 7'b1000000
  } scan_mode_t;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [NUM_KW-1:0] KW_ALL = {NUM_KW{1'b1}};

  // keyword text, padded with zeros
  localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
    '{8'h64, 8'h65, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h78, 8'h74, 8'h65, 8'h72, 8'h6E, 8'h00, 8'h00},
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h69, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd3, 4'd6, 4'd2, 4'd4, 4'd3, 4'd2};

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  single_char;
    logic [31:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  typedef struct packed {
    scan_mode_t          mode;
    logic [NUM_KW-1:0]   cand;
    logic [LEN_BITS-1:0] cur_len;
    logic [POS_BITS-1:0] cur_start;
    logic [POS_BITS-1:0] pos;
  } scan_st_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] a);
    return (a == LEN_MAX) ? LEN_MAX : a + LEN_BITS'(1);
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc2(input logic [LEN_BITS-1:0] a);
    return (a >= LEN_MAX - LEN_BITS'(1)) ? LEN_MAX : a + LEN_BITS'(2);
  endfunction

  function automatic logic [15:0] len_out(input logic [LEN_BITS-1:0] a);
    logic [15:0] r;
    if (LEN_BITS > 16 && a > LEN_BITS'(16'hFFFF)) r = 16'hFFFF;
    else r = 16'(a);
    return r;
  endfunction

  function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                               input logic [7:0] c,
                                               input logic [LEN_BITS-1:0] idx);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (cand[k] && idx < LEN_BITS'(KW_LEN[k]) && KW_TEXT[k][idx[2:0]] == c) r[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic tok_kind_t ident_kind(input logic [NUM_KW-1:0] cand,
                                           input logic [LEN_BITS-1:0] len);
    tok_kind_t r;
    r = KIND_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cand[k] && len == LEN_BITS'(KW_LEN[k])) r = tok_kind_t'(4'(k + 1));
    end
    return r;
  endfunction

  function automatic token_t mk_tok(input tok_kind_t kind, input logic [7:0] ch,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [LEN_BITS-1:0] len);
    token_t t;
    t.kind = kind;
    t.single_char = ch;
    t.start = 32'(start);
    t.length = len_out(len);
    t.last = 1'b0;
    return t;
  endfunction

endpackage
`default_nettype wire

### src/tls_scan.sv
`default_nettype none
module tls_scan (
  input  wire tls_pkg::scan_st_t          st,
  input  wire logic [7:0]                 c,
  input  wire logic                       eoi,
  output tls_pkg::scan_st_t               st_nxt,
  output tls_pkg::token_t                 tok [tls_pkg::MAX_TOK],
  output logic [1:0]                      tok_cnt
);

  logic                         used;
  logic                         do_flush;
  logic [tls_pkg::POS_BITS-1:0] prev;

  assign prev = st.pos - tls_pkg::POS_BITS'(1);

  always_comb begin
    st_nxt = st;
    used = 1'b0;
    do_flush = 1'b0;
    tok_cnt = '0;
    for (int i = 0; i < tls_pkg::MAX_TOK; i++) tok[i] = '0;

    if (!eoi) begin
      unique case (st.mode)
        tls_pkg::MODE_IDENT: begin
          if (tls_pkg::is_alpha(c) || tls_pkg::is_digit(c) || c == tls_pkg::CH_UNDER) begin
            st_nxt.cand = tls_pkg::narrow(st.cand, c, st.cur_len);
            st_nxt.cur_len = tls_pkg::len_inc(st.cur_len);
            used = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        tls_pkg::MODE_INT: begin
          if (tls_pkg::is_digit(c)) begin
            st_nxt.cur_len = tls_pkg::len_inc(st.cur_len);
            used = 1'b1;
          end else if (c == tls_pkg::CH_DOT) begin
            st_nxt.mode = tls_pkg::MODE_INTDOT;
            used = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        tls_pkg::MODE_INTDOT: begin
          if (tls_pkg::is_digit(c)) begin
            st_nxt.cur_len = tls_pkg::len_inc2(st.cur_len);
            st_nxt.mode = tls_pkg::MODE_FRAC;
            used = 1'b1;
          end else if (c == tls_pkg::CH_DOT) begin
            tok[0] = tls_pkg::mk_tok(tls_pkg::KIND_NUMBER, 8'h00, st.cur_start, st.cur_len);
            tok[1] = tls_pkg::mk_tok(tls_pkg::KIND_DOTDOT, 8'h00, prev,
                                     tls_pkg::LEN_BITS'(2));
            tok_cnt = 2'd2;
            st_nxt.mode = tls_pkg::MODE_IDLE;
            used = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        tls_pkg::MODE_FRAC: begin
          if (tls_pkg::is_digit(c)) begin
            st_nxt.cur_len = tls_pkg::len_inc(st.cur_len);
            used = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        tls_pkg::MODE_DOT: begin
          if (c == tls_pkg::CH_DOT) begin
            tok[0] = tls_pkg::mk_tok(tls_pkg::KIND_DOTDOT, 8'h00, st.cur_start,
                                     tls_pkg::LEN_BITS'(2));
            tok_cnt = 2'd1;
            st_nxt.mode = tls_pkg::MODE_IDLE;
            used = 1'b1;
          end else begin
            do_flush = 1'b1;
          end
        end
        tls_pkg::MODE_COMMENT: begin
          if (c == tls_pkg::CH_LF || c == tls_pkg::CH_CR) st_nxt.mode = tls_pkg::MODE_IDLE;
          else used = 1'b1;
        end
        default: begin
          st_nxt.mode = tls_pkg::MODE_IDLE;
        end
      endcase
    end else begin
      do_flush = 1'b1;
    end

    // emit the pending token, and for a number ending in a dot also that dot
    if (do_flush) begin
      unique case (st.mode)
        tls_pkg::MODE_IDENT: begin
          tok[0] = tls_pkg::mk_tok(tls_pkg::ident_kind(st.cand, st.cur_len), 8'h00,
                                   st.cur_start, st.cur_len);
          tok_cnt = 2'd1;
        end
        tls_pkg::MODE_INT, tls_pkg::MODE_FRAC: begin
          tok[0] = tls_pkg::mk_tok(tls_pkg::KIND_NUMBER, 8'h00, st.cur_start, st.cur_len);
          tok_cnt = 2'd1;
        end
        tls_pkg::MODE_INTDOT: begin
          tok[0] = tls_pkg::mk_tok(tls_pkg::KIND_NUMBER, 8'h00, st.cur_start, st.cur_len);
          tok[1] = tls_pkg::mk_tok(tls_pkg::KIND_SINGLE, tls_pkg::CH_DOT, prev,
                                   tls_pkg::LEN_BITS'(1));
          tok_cnt = 2'd2;
        end
        tls_pkg::MODE_DOT: begin
          tok[0] = tls_pkg::mk_tok(tls_pkg::KIND_SINGLE, tls_pkg::CH_DOT, st.cur_start,
                                   tls_pkg::LEN_BITS'(1));
          tok_cnt = 2'd1;
        end
        default: begin
        end
      endcase
      st_nxt.mode = tls_pkg::MODE_IDLE;
    end

    if (eoi) begin
      tok[tok_cnt] = tls_pkg::mk_tok(tls_pkg::KIND_EOF, 8'h00, st.pos, '0);
      tok_cnt = tok_cnt + 2'd1;
      st_nxt.mode = tls_pkg::MODE_IDLE;
      st_nxt.cand = tls_pkg::KW_ALL;
      st_nxt.cur_len = '0;
      st_nxt.cur_start = '0;
      st_nxt.pos = '0;
    end else begin
      if (!used) begin
        if (c == tls_pkg::CH_SPACE || c == tls_pkg::CH_TAB) begin
          // skipped
        end else if (tls_pkg::is_alpha(c)) begin
          st_nxt.mode = tls_pkg::MODE_IDENT;
          st_nxt.cur_start = st.pos;
          st_nxt.cur_len = tls_pkg::LEN_BITS'(1);
          st_nxt.cand = tls_pkg::narrow(tls_pkg::KW_ALL, c, '0);
        end else if (tls_pkg::is_digit(c)) begin
          st_nxt.mode = tls_pkg::MODE_INT;
          st_nxt.cur_start = st.pos;
          st_nxt.cur_len = tls_pkg::LEN_BITS'(1);
        end else if (c == tls_pkg::CH_DOT) begin
          st_nxt.mode = tls_pkg::MODE_DOT;
          st_nxt.cur_start = st.pos;
          st_nxt.cur_len = tls_pkg::LEN_BITS'(1);
        end else if (c == tls_pkg::CH_HASH) begin
          st_nxt.mode = tls_pkg::MODE_COMMENT;
        end else begin
          tok[tok_cnt] = tls_pkg::mk_tok(tls_pkg::KIND_SINGLE, c, st.pos,
                                         tls_pkg::LEN_BITS'(1));
          tok_cnt = tok_cnt + 2'd1;
        end
      end
      st_nxt.pos = st.pos + tls_pkg::POS_BITS'(1);
    end

    if (tok_cnt != 2'd0) tok[tok_cnt - 2'd1].last = 1'b1;
  end

endmodule
`default_nettype wire

### src/toy_language_token_scanner.sv
`default_nettype none
// channel  | direction | tdata (low bit up)                                   | tlast
// in_      | slave     | char_byte[7:0]                                       | end_of_input
// out_     | master    | token_kind[3:0] single_char[11:4] token_start[43:12] | last_of_run
//          |           | token_length[59:44] zero[63:60]                      |
//
// one source byte is scanned per cycle while input is taken; a byte that yields k
// tokens writes all k into the queue together, and a four-entry token queue absorbs
// up to three tokens per byte. input is taken whenever the queue has room for three
// tokens. synchronous active-low reset returns the scanner to its idle state.
// an output stall backs up into in_tready once the queue holds two or more.
module toy_language_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // char_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // token_kind, single_char, token_start, token_length
  output logic             out_tlast   // last_of_run
);

  tls_pkg::scan_st_t st_r;
  tls_pkg::scan_st_t st_nxt;
  tls_pkg::token_t   tok [tls_pkg::MAX_TOK];
  logic [1:0]        tok_cnt;

  tls_pkg::token_t               fifo_r [tls_pkg::FIFO_DEPTH];
  logic [tls_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tls_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tls_pkg::FIFO_AW:0]     count_r, count_nxt;
  logic                          in_fire;
  logic                          out_fire;
  tls_pkg::token_t               head;

  tls_scan u_scan (
    .st      (st_r),
    .c       (in_tdata),
    .eoi     (in_tlast),
    .st_nxt  (st_nxt),
    .tok     (tok),
    .tok_cnt (tok_cnt)
  );

  assign in_tready = count_r <= (tls_pkg::FIFO_AW + 1)'(tls_pkg::FIFO_DEPTH - tls_pkg::MAX_TOK);
  assign in_fire = in_tvalid && in_tready;
  assign out_tvalid = count_r != '0;
  assign out_fire = out_tvalid && out_tready;
  assign head = fifo_r[rd_ptr_r];
  assign out_tdata = {4'h0, head.length, head.start, head.single_char, head.kind};
  assign out_tlast = head.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + tls_pkg::FIFO_AW'(tok_cnt);
      count_nxt = count_nxt + (tls_pkg::FIFO_AW + 1)'(tok_cnt);
    end
    if (out_fire) begin
      rd_ptr_nxt = rd_ptr_r + tls_pkg::FIFO_AW'(1);
      count_nxt = count_nxt - (tls_pkg::FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= tls_pkg::MODE_IDLE;
      st_r.cand <= tls_pkg::KW_ALL;
      st_r.cur_len <= '0;
      st_r.cur_start <= '0;
      st_r.pos <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (in_fire) st_r <= st_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < tls_pkg::MAX_TOK; i++) begin
        if (2'(i) < tok_cnt) fifo_r[wr_ptr_r + tls_pkg::FIFO_AW'(i)] <= tok[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (tls_pkg::FIFO_AW + 1)'(tls_pkg::FIFO_DEPTH))
    else $error("token queue overflow");

  a_eoi_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> out_tvalid)
    else $error("end of input produced no token");

  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> st_r.pos == '0 && st_r.mode == tls_pkg::MODE_IDLE)
    else $error("scanner state not cleared after end of input");

  a_last_on_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && head.kind == tls_pkg::KIND_EOF |-> out_tlast)
    else $error("eof token without last flag");

endmodule
`default_nettype wire

### tb/tb_toy_language_token_scanner.sv
`timescale 1ns / 100ps

module tb_toy_language_token_scanner;
  import tls_pkg::*;

  localparam int N_PLAN = 25;
  localparam int HOLD_CYCLES = 80;
  localparam int unsigned SAT_LEN = 65535;

  typedef struct packed {
    logic        eoi;
    logic [7:0]  ch;
    logic        typed;
    tok_kind_t   kind;
    logic [7:0]  sc;
    logic [31:0] start;
    logic [15:0] len;
  } scan_row_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [7:0]  sc;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;

  toy_language_token_scanner u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // directed bytes; typed rows carry their single token
  scan_row_t plan_rows [N_PLAN] = '{
    '{1'b1, 8'h00, 1'b1, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, 8'h00, 1'b1, KIND_SINGLE, 8'h00, 32'd0, 16'd1},
    '{1'b0, 8'hFF, 1'b1, KIND_SINGLE, 8'hFF, 32'd1, 16'd1},
    '{1'b0, "d", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "e", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "f", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_SPACE, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "i", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "n", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_TAB, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "1", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_DOT, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "+", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "9", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_DOT, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_DOT, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_DOT, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "5", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_HASH, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "Z", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_CR, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, "z", 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_UNDER, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b0, CH_DOT, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0},
    '{1'b1, 8'h00, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0}
  };

  scan_row_t  src_bytes [$];
  token_rec_t step_toks [$];
  token_rec_t tokens_due [$];

  scan_mode_t  sc_mode;
  logic [5:0]  sc_cand;
  int unsigned sc_len;
  logic [31:0] sc_start;
  logic [31:0] sc_pos;

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int n_err = 0;
  int n_items = 0;
  int n_tokens = 0;
  int n_multi = 0;

  function automatic string kw_word(input int k);
    case (k)
      0: return "def";
      1: return "extern";
      2: return "if";
      3: return "else";
      4: return "for";
      default: return "in";
    endcase
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int unsigned grow(input int unsigned a, input int unsigned b);
    return (a + b >= SAT_LEN) ? SAT_LEN : a + b;
  endfunction

  function automatic logic [5:0] narrow_cand(input logic [5:0] cd, input logic [7:0] c,
                                             input int unsigned idx);
    logic [5:0] r;
    string w;
    r = '0;
    for (int k = 0; k < 6; k++) begin
      w = kw_word(k);
      if (cd[k] && idx < w.len() && w[idx] == c) r[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic tok_kind_t word_kind();
    string w;
    for (int k = 0; k < 6; k++) begin
      w = kw_word(k);
      if (sc_cand[k] && sc_len == w.len()) return tok_kind_t'(KIND_DEF + k);
    end
    return KIND_IDENT;
  endfunction

  task automatic reset_scanner();
    sc_mode = MODE_IDLE;
    sc_cand = 6'h3F;
    sc_len = 0;
    sc_start = '0;
    sc_pos = '0;
  endtask

  task automatic put_tok(input tok_kind_t kind, input logic [7:0] c,
                         input logic [31:0] start, input int unsigned len);
    token_rec_t t;
    t.kind = kind;
    t.sc = c;
    t.start = start;
    t.len = 16'(len);
    t.last = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic flush_pending(input logic [31:0] prev);
    case (sc_mode)
      MODE_IDENT: put_tok(word_kind(), 8'h00, sc_start, sc_len);
      MODE_INT, MODE_FRAC: put_tok(KIND_NUMBER, 8'h00, sc_start, sc_len);
      MODE_INTDOT: begin
        put_tok(KIND_NUMBER, 8'h00, sc_start, sc_len);
        put_tok(KIND_SINGLE, CH_DOT, prev, 1);
      end
      MODE_DOT: put_tok(KIND_SINGLE, CH_DOT, sc_start, 1);
      default: ;
    endcase
    sc_mode = MODE_IDLE;
  endtask

  task automatic scan_char(input logic eoi, input logic [7:0] c);
    logic [31:0] prev;
    bit used;
    prev = sc_pos - 32'd1;
    used = 1'b0;
    step_toks.delete();
    if (eoi) begin
      flush_pending(prev);
      put_tok(KIND_EOF, 8'h00, sc_pos, 0);
      reset_scanner();
    end else begin
      case (sc_mode)
        MODE_IDENT: begin
          if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
            sc_cand = narrow_cand(sc_cand, c, sc_len);
            sc_len = grow(sc_len, 1);
            used = 1'b1;
          end else flush_pending(prev);
        end
        MODE_INT: begin
          if (is_numeral(c)) begin
            sc_len = grow(sc_len, 1);
            used = 1'b1;
          end else if (c == CH_DOT) begin
            sc_mode = MODE_INTDOT;
            used = 1'b1;
          end else flush_pending(prev);
        end
        MODE_INTDOT: begin
          if (is_numeral(c)) begin
            sc_len = grow(sc_len, 2);
            sc_mode = MODE_FRAC;
            used = 1'b1;
          end else if (c == CH_DOT) begin
            put_tok(KIND_NUMBER, 8'h00, sc_start, sc_len);
            put_tok(KIND_DOTDOT, 8'h00, prev, 2);
            sc_mode = MODE_IDLE;
            used = 1'b1;
          end else flush_pending(prev);
        end
        MODE_FRAC: begin
          if (is_numeral(c)) begin
            sc_len = grow(sc_len, 1);
            used = 1'b1;
          end else flush_pending(prev);
        end
        MODE_DOT: begin
          if (c == CH_DOT) begin
            put_tok(KIND_DOTDOT, 8'h00, sc_start, 2);
            sc_mode = MODE_IDLE;
            used = 1'b1;
          end else flush_pending(prev);
        end
        MODE_COMMENT: begin
          if (c == CH_LF || c == CH_CR) sc_mode = MODE_IDLE;
          else used = 1'b1;
        end
        default: sc_mode = MODE_IDLE;
      endcase
      if (!used) begin
        if (c == CH_SPACE || c == CH_TAB) begin
        end else if (is_letter(c)) begin
          sc_mode = MODE_IDENT;
          sc_start = sc_pos;
          sc_len = 1;
          sc_cand = narrow_cand(6'h3F, c, 0);
        end else if (is_numeral(c)) begin
          sc_mode = MODE_INT;
          sc_start = sc_pos;
          sc_len = 1;
        end else if (c == CH_DOT) begin
          sc_mode = MODE_DOT;
          sc_start = sc_pos;
          sc_len = 1;
        end else if (c == CH_HASH) begin
          sc_mode = MODE_COMMENT;
        end else put_tok(KIND_SINGLE, c, sc_pos, 1);
      end
      sc_pos = sc_pos + 32'd1;
    end
  endtask

  task automatic add_byte(input logic eoi, input logic [7:0] c);
    scan_row_t r;
    r = '{eoi, c, 1'b0, KIND_EOF, 8'h00, 32'd0, 16'd0};
    src_bytes.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(1'b0, s[i]);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) add_byte(1'b0, pick("0123456789"));
  endtask

  task automatic add_random_word();
    string letters;
    string w;
    int v;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    case ($urandom_range(0, 11))
      0, 1: begin
        w = kw_word($urandom_range(0, 5));
        v = $urandom_range(0, 3);
        if (v == 0) w = w.substr(0, w.len() - 2);
        add_text(w);
        if (v == 1) add_byte(1'b0, pick({letters, "0123456789_"}));
      end
      2: begin
        add_byte(1'b0, pick(letters));
        repeat ($urandom_range(0, 6)) add_byte(1'b0, pick({letters, "0123456789_"}));
      end
      3, 4: begin
        add_digits(1, 4);
        case ($urandom_range(0, 3))
          0: begin
            add_byte(1'b0, CH_DOT);
            add_digits(1, 3);
          end
          1: add_text("..");
          2: begin
            add_byte(1'b0, CH_DOT);
            add_byte(1'b0, 8'($urandom_range(0, 255)));
          end
          default: ;
        endcase
      end
      5: add_text($urandom_range(0, 1) ? ".." : ".");
      6: begin
        add_byte(1'b0, CH_HASH);
        repeat ($urandom_range(0, 8)) add_byte(1'b0, 8'($urandom_range(0, 255)));
        add_byte(1'b0, $urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      7: add_byte(1'b0, pick("+-*/()<>=;,!"));
      8: add_byte(1'b0, $urandom_range(0, 1) ? CH_LF : CH_CR);
      9: add_byte(1'b0, 8'($urandom_range(0, 255)));
      10: add_byte(1'b1, 8'($urandom_range(0, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) add_byte(1'b0, $urandom_range(0, 1) ? CH_SPACE : CH_TAB);
  endtask

  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("toy_language_token_scanner verification failed");
    $finish;
  end

  // receiver side
  initial begin
    int n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    token_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tokens_due.size() == 0) begin
        $error("token with no expectation waiting: %h last %b", out_tdata, out_tlast);
        n_err++;
      end else begin
        want = tokens_due.pop_front();
        n_tokens++;
        if (out_tdata[3:0] !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_tdata[3:0]);
          n_err++;
        end
        if (out_tdata[11:4] !== want.sc) begin
          $error("single_char: expected %0d, got %0d", want.sc, out_tdata[11:4]);
          n_err++;
        end
        if (out_tdata[43:12] !== want.start) begin
          $error("token_start: expected %0d, got %0d", want.start, out_tdata[43:12]);
          n_err++;
        end
        if (out_tdata[59:44] !== want.len) begin
          $error("token_length: expected %0d, got %0d", want.len, out_tdata[59:44]);
          n_err++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
          n_err++;
        end
      end
    end
  end

  // sender side and prediction
  initial begin
    scan_row_t it;
    token_rec_t t;
    int quiet_from;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;

    for (int i = 0; i < N_PLAN; i++) src_bytes.push_back(plan_rows[i]);
    while (src_bytes.size() < N_PLAN + 375) add_random_word();
    quiet_from = src_bytes.size();
    while (src_bytes.size() < quiet_from + 100) add_random_word();
    add_byte(1'b1, 8'h00);

    reset_scanner();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < src_bytes.size(); i++) begin
      it = src_bytes[i];
      if (i == N_PLAN) hold_req = 1'b1;
      if (i == quiet_from) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= it.ch;
      in_tlast <= it.eoi;
      do @(posedge clk); while (in_tready !== 1'b1);
      n_items++;
      scan_char(it.eoi, it.ch);
      if (step_toks.size() > 1) n_multi++;
      if (it.typed) begin
        t = '{it.kind, it.sc, it.start, it.len, 1'b1};
        tokens_due.push_back(t);
      end else begin
        for (int k = 0; k < step_toks.size(); k++) begin
          t = step_toks[k];
          t.last = (k == step_toks.size() - 1);
          tokens_due.push_back(t);
        end
      end
      @(negedge clk);
    end
    in_tvalid <= 1'b0;

    wait (tokens_due.size() == 0);
    repeat (20) @(posedge clk);
    $display("scanned %0d bytes, checked %0d tokens, %0d bytes gave more than one token",
             n_items, n_tokens, n_multi);
    $display("covered keywords, numbers, dots, comments, odd bytes and end of input under stalls");
    if (n_err == 0) begin
      $display("toy_language_token_scanner verification clean");
    end else begin
      $display("toy_language_token_scanner verification failed");
    end
    $finish;
  end

endmodule
